FILE: sv/ccx_pkg.sv
// package for the chacha20 stream xor unit: constants, types and the quarter round
// no dependencies
package ccx_pkg;

    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 64;
    localparam int unsigned DefDoubleRounds = 10;

    localparam logic [CfgIdxW-1:0] REG_KEY0  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY1  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY2  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY3  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_NONCE_LO = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_NONCE_HI = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_INIT_CTR = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    // queued item from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       gen;      // generate a new block before this byte
        logic [5:0] offset;   // byte offset within the block
        logic [31:0] counter; // block counter used when gen is set
    } t_item;

    typedef logic [15:0][31:0] t_words;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // one quarter round on four words, in place order a,b,c,d
    function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a; tb = b; tc = c; td = d;
        ta = ta + tb; td = rotl(td ^ ta, 16);
        tc = tc + td; tb = rotl(tb ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qround = {td, tc, tb, ta};
    endfunction

endpackage

FILE: sv/chacha20_stream_xor_unit.sv
// top level of the chacha20 stream xor unit: config registers, front, queue, back
// depends on ccx_pkg, ccx_front, ccx_fifo, ccx_back
//
// xors a byte stream with the chacha20 keystream (96-bit nonce, 32-bit block
// counter). a byte is xored in the back end without waiting for a block, except
// the first byte of each 64-byte block, which waits while the shared round unit
// runs one column or diagonal round a cycle to build the keystream block.
// tuser bit 0 restarts the counter from the initial_counter register and the
// offset at this beat.
// the user must write the registers only while the unit is idle; the unit
// does not enforce this. a key or nonce change applies at the next block
module chacha20_stream_xor_unit import ccx_pkg::*; #(
    parameter int unsigned DOUBLE_ROUNDS = DefDoubleRounds
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,  // data_byte
    input  logic                s_axis_tuser,  // restart
    input  logic                s_axis_tlast,  // last_of_message
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,  // out_byte
    output logic                m_axis_tlast   // last_out
);
    logic [255:0] r_key;
    logic [95:0]  r_nonce;
    logic [31:0]  r_init_ctr;
    logic  w_push, w_full, w_pop, w_qvalid;
    t_item w_fitem, w_qitem;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0; r_nonce <= '0; r_init_ctr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY0:     r_key[63:0]    <= i_cfg_data;
                REG_KEY1:     r_key[127:64]  <= i_cfg_data;
                REG_KEY2:     r_key[191:128] <= i_cfg_data;
                REG_KEY3:     r_key[255:192] <= i_cfg_data;
                REG_NONCE_LO: r_nonce[63:0]  <= i_cfg_data;
                REG_NONCE_HI: r_nonce[95:64] <= i_cfg_data[31:0];
                REG_INIT_CTR: r_init_ctr     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    ccx_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .i_restart(s_axis_tuser), .i_last(s_axis_tlast),
        .i_init_counter(r_init_ctr),
        .o_push(w_push), .o_item(w_fitem), .i_full(w_full)
    );

    ccx_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_item(w_fitem), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_qvalid), .o_item(w_qitem)
    );

    ccx_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qvalid), .i_item(w_qitem), .o_pop(w_pop),
        .i_key(r_key), .i_nonce(r_nonce),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_byte(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule

FILE: sv/ccx_front.sv
// front end: accepts bytes, tracks counter and offset, tags block generation
// depends on ccx_pkg
module ccx_front import ccx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data,
    input  logic        i_restart,
    input  logic        i_last,
    input  logic [31:0] i_init_counter,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_full
);
    logic [31:0] r_counter, n_counter;
    logic [5:0]  r_offset, n_offset;
    logic [31:0] w_ctr;
    logic [5:0]  w_off;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_ctr   = i_restart ? i_init_counter : r_counter;
    assign w_off   = i_restart ? 6'd0 : r_offset;

    always_comb begin
        o_item.data    = i_data;
        o_item.last    = i_last;
        o_item.gen     = (w_off == 6'd0);
        o_item.offset  = w_off;
        o_item.counter = w_ctr;
        n_counter = (w_off == 6'd0) ? w_ctr + 32'd1 : w_ctr;
        n_offset  = w_off + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_offset  <= '0;
        end else if (o_push) begin
            r_counter <= n_counter;
            r_offset  <= n_offset;
        end
    end
endmodule

FILE: sv/ccx_fifo.sv
// short queue between front and back
// depends on ccx_pkg
module ccx_fifo import ccx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end
endmodule

FILE: sv/ccx_back.sv
// back end: chacha20 block core (one column or diagonal round per cycle) and xor
// depends on ccx_pkg
module ccx_back import ccx_pkg::*; #(
    parameter int unsigned DOUBLE_ROUNDS = DefDoubleRounds
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [255:0] i_key,
    input  logic [95:0]  i_nonce,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte,
    output logic        o_last
);
    localparam int unsigned RoundW = $clog2(2 * DOUBLE_ROUNDS + 1);
    localparam logic [RoundW-1:0] LastRound = RoundW'(2 * DOUBLE_ROUNDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_GEN  = 2'b10
    } t_state;

    t_state r_state;
    t_words r_init, r_w, r_ks, w_init, w_round;
    logic [RoundW-1:0] r_round;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        w_out_free;
    logic [31:0] w_ksw;
    logic [7:0]  w_ksb;

    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        w_init[0] = SIGMA0; w_init[1] = SIGMA1; w_init[2] = SIGMA2; w_init[3] = SIGMA3;
        for (int i = 0; i < 8; i++) w_init[4+i] = i_key[32*i +: 32];
        w_init[12] = i_item.counter;
        w_init[13] = i_nonce[31:0];
        w_init[14] = i_nonce[63:32];
        w_init[15] = i_nonce[95:64];
    end

    // even rounds are column rounds, odd rounds diagonal rounds
    always_comb begin
        w_round = r_w;
        if (!r_round[0]) begin
            for (int c = 0; c < 4; c++)
                {w_round[12+c], w_round[8+c], w_round[4+c], w_round[c]} =
                    qround(r_w[c], r_w[4+c], r_w[8+c], r_w[12+c]);
        end else begin
            for (int c = 0; c < 4; c++)
                {w_round[12+(c+3)%4], w_round[8+(c+2)%4], w_round[4+(c+1)%4], w_round[c]} =
                    qround(r_w[c], r_w[4+(c+1)%4], r_w[8+(c+2)%4], r_w[12+(c+3)%4]);
        end
    end

    assign w_ksw = r_ks[i_item.offset[5:2]];
    assign w_ksb = w_ksw[8*i_item.offset[1:0] +: 8];
    assign o_pop = (r_state == ST_IDLE) && i_valid && !i_item.gen && w_out_free
                   || (r_state == ST_GEN) && (r_round == LastRound + RoundW'(1)) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_round  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && i_item.gen) begin
                        r_state <= ST_GEN;
                        r_round <= '0;
                    end else if (o_pop) begin
                        r_ovalid <= 1'b1;
                    end
                end
                ST_GEN: begin
                    if (r_round <= LastRound) begin
                        r_round <= r_round + RoundW'(1);
                    end else if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid && i_item.gen) begin
            r_init <= w_init;
            r_w    <= w_init;
        end else if (r_state == ST_GEN && r_round <= LastRound) begin
            r_w <= w_round;
            if (r_round == LastRound)
                for (int i = 0; i < 16; i++) r_ks[i] <= w_round[i] + r_init[i];
        end
        if (o_pop) begin
            r_obyte <= i_item.data ^ w_ksb;
            r_olast <= i_item.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
endmodule

FILE: tb/tb_chacha20_stream_xor_unit.sv
// self-checking testbench for the chacha20 stream xor unit
// depends on ccx_pkg and chacha20_stream_xor_unit; keystream predicted in a scoreboard class
`timescale 1ns / 1ps

module tb_chacha20_stream_xor_unit;
    import ccx_pkg::*;

    localparam int unsigned DBL_ROUNDS = 10;
    localparam int unsigned ITEM_GOAL = 1750;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 100;
    // index past the register list, the unit must ignore it
    localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

    // expected output beat
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    // keystream predictor and store of expected output beats
    class xor_scoreboard;
        logic [63:0] key_q [4];
        logic [63:0] nonce_lo;
        logic [31:0] nonce_hi;
        logic [31:0] ctr_init;
        logic [31:0] ctr;
        logic [31:0] ks [16];
        logic [5:0]  offset;
        t_out_beat   pending [$];
        int unsigned errors;

        function new();
            for (int i = 0; i < 4; i++) key_q[i] = '0;
            for (int i = 0; i < 16; i++) ks[i] = '0;
            nonce_lo = '0; nonce_hi = '0; ctr_init = '0; ctr = '0;
            offset = '0; errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
            case (idx)
                REG_KEY0:     key_q[0] = val;
                REG_KEY1:     key_q[1] = val;
                REG_KEY2:     key_q[2] = val;
                REG_KEY3:     key_q[3] = val;
                REG_NONCE_LO: nonce_lo = val;
                REG_NONCE_HI: nonce_hi = val[31:0];
                REG_INIT_CTR: ctr_init = val[31:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] rot_left(logic [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void mix(ref logic [31:0] w [16], input int a, int b, int c, int d);
            w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
            w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
            w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
            w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
        endfunction

        // build the next keystream block from the live key and nonce
        function void next_block();
            logic [31:0] seed [16];
            logic [31:0] w [16];
            seed[0] = SIGMA0; seed[1] = SIGMA1; seed[2] = SIGMA2; seed[3] = SIGMA3;
            for (int i = 0; i < 4; i++) begin
                seed[4 + 2 * i] = key_q[i][31:0];
                seed[5 + 2 * i] = key_q[i][63:32];
            end
            seed[12] = ctr;
            seed[13] = nonce_lo[31:0];
            seed[14] = nonce_lo[63:32];
            seed[15] = nonce_hi;
            w = seed;
            for (int r = 0; r < DBL_ROUNDS; r++) begin
                mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
                mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
                mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
                mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) ks[i] = w[i] + seed[i];
            ctr = ctr + 32'd1;
        endfunction

        function void note_input(logic [7:0] data, logic restart, logic last);
            t_out_beat b;
            logic [31:0] word;
            if (restart) begin
                ctr = ctr_init;
                offset = '0;
            end
            if (offset == 6'd0) next_block();
            word = ks[offset[5:2]];
            b.data = data ^ 8'(word >> (8 * offset[1:0]));
            b.last = last;
            offset = offset + 6'd1;
            pending.push_back(b);
        endfunction

        function void check_result(logic [7:0] data, logic last);
            t_out_beat b;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat data %02h last %0b", data, last));
                return;
            end
            b = pending.pop_front();
            if (data !== b.data)
                report($sformatf("data %02h, predicted %02h", data, b.data));
            if (last !== b.last)
                report($sformatf("last %0b, predicted %0b", last, b.last));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;  // data_byte
    logic                s_axis_tuser;  // restart
    logic                s_axis_tlast;  // last_of_message
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;  // out_byte
    logic                m_axis_tlast;  // last_out

    xor_scoreboard sb = new();
    int unsigned   cycle_no = 0;
    int unsigned   stall_cycles = 0;
    int unsigned   sent = 0;

    chacha20_stream_xor_unit #(.DOUBLE_ROUNDS(DBL_ROUNDS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // quiet window: neither side idles here
    function automatic bit idle_now();
        if (cycle_no >= 3000 && cycle_no < 3700) return 1'b0;
        return $urandom_range(99) < 25;
    endfunction

    // sink side: random back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= (i_rst_n == 1'b1) ? !idle_now() : 1'b0;
    end

    // output check, acceptance tracking and watchdog
    always @(posedge i_clk) begin
        cycle_no++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // one beat into the unit; valid stays high between back-to-back beats
    task automatic send_beat(logic [7:0] data, logic restart, logic last);
        if (idle_now()) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = data;
        s_axis_tuser = restart;
        s_axis_tlast = last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(data, restart, last);
        sent++;
    endtask

    // sender holds off until every predicted beat is out, then lets the unit settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick64();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_ctr();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;   // wraps at the next block
            2:       return 32'hffff_fffe;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned len;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);

        // directed: zero key straight out of reset, no restart on the first beat
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h5a, 1'b1, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b1);
        drain();
        // all-ones key and nonce, counter about to wrap
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY1, '1);
        write_reg(REG_KEY2, '1);
        write_reg(REG_KEY3, '1);
        write_reg(REG_NONCE_LO, '1);
        write_reg(REG_NONCE_HI, 64'hffff_ffff);
        write_reg(REG_INIT_CTR, 64'hffff_ffff);
        write_reg(REG_SPARE, '1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
        drain();
        // key change without restart; these beats stay in the current block, whose keystream came from the old key
        write_reg(REG_KEY2, 64'h0123_4567_89ab_cdef);
        for (int i = 0; i < 12; i++) send_beat(8'($urandom), 1'b0, i == 11);
        drain();

        // random phases of messages under random settings
        while (sent < ITEM_GOAL) begin
            for (int r = 0; r < 7; r++)
                if ($urandom_range(2) == 0) write_reg(CfgIdxW'(r), pick64());
            if ($urandom_range(3) == 0) write_reg(REG_INIT_CTR, {32'h0, pick_ctr()});
            if ($urandom_range(7) == 0) write_reg(REG_SPARE, pick64());
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(130, 200)
                                               : $urandom_range(1, 70);
                for (int i = 0; i < len; i++) begin
                    send_beat(8'($urandom),
                              (i == 0) ? ($urandom_range(4) != 0) : ($urandom_range(60) == 0),
                              (i == len - 1) ? ($urandom_range(9) != 0)
                                             : ($urandom_range(40) == 0));
                end
            end
            drain();
        end

        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d beats never came out", sb.pending.size()));
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/ccx_pkg.sv
sv/ccx_front.sv
sv/ccx_fifo.sv
sv/ccx_back.sv
sv/chacha20_stream_xor_unit.sv
tb/tb_chacha20_stream_xor_unit.sv
